>>> hw/rtl/indexed_list_store_top_assert.svh
// ----------------------------------------------------------------------------
// indexed_list_store_top_assert.svh
// assertion macros for the indexed list store
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_TOP_ASSERT_SVH
`define INDEXED_LIST_STORE_TOP_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define ILS_ASSERT_SAME(label, clk_s, rst_s, cond, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |-> (cons)) \
    else $error("assertion failed");

// condition in this cycle implies consequence in the next cycle
`define ILS_ASSERT_NEXT(label, clk_s, rst_s, cond, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// constants, codes and control types of the indexed list store
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/ils_if.sv
// ----------------------------------------------------------------------------
// ils_if
// command and result channels of the indexed list store
// ----------------------------------------------------------------------------
`default_nettype none

interface ils_cmd_if;
  import ils_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [POS_W-1:0]     position;
  logic [VALUE_W-1:0]   item_value;

  modport source (output valid, output command, output position, output item_value,
                  input ready);
  modport sink   (input valid, input command, input position, input item_value,
                  output ready);
endinterface

interface ils_res_if;
  import ils_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [VALUE_W-1:0]   read_value;
  logic [COUNT_W-1:0]   count;
  logic                 empty_res;

  modport source (output valid, output ok, output read_value, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input ok, input read_value, input count,
                  input empty_res, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// handshake controller: issues one load per transaction, holds result valid
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ils_pkg::ctl_cmd_t    cmd
);
  import ils_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state;
  logic state_next;

  // a new transaction may enter while the held result is being taken
  assign in_ready  = (state == ST_IDLE) || out_ready;
  assign out_valid = (state == ST_HOLD);
  assign cmd.load  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready && !cmd.load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ils_dp.sv
// ----------------------------------------------------------------------------
// ils_dp
// list datapath: register array with parallel shift, fill count, result regs
// ----------------------------------------------------------------------------
`default_nettype none

module ils_dp (
  input  wire                           clk,
  input  wire                           rst,
  input  ils_pkg::ctl_cmd_t             cmd,
  input  wire [ils_pkg::CMD_W-1:0]      command,
  input  wire [ils_pkg::POS_W-1:0]      position,
  input  wire [ils_pkg::VALUE_W-1:0]    item_value,
  output ils_pkg::dp_status_t           status,
  output logic                          ok,
  output logic [ils_pkg::VALUE_W-1:0]   read_value,
  output logic [ils_pkg::COUNT_W-1:0]   count,
  output logic                          empty_res
);
  import ils_pkg::*;

  logic [ITEM_WIDTH-1:0] entries      [DEPTH];
  logic [ITEM_WIDTH-1:0] entries_next [DEPTH];
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic                  ok_next;
  logic [VALUE_W-1:0]    read_next;

  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      cnt_c;
  logic [ITEM_WIDTH-1:0] val;
  logic                  full;

  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(cnt);
  assign val   = ITEM_WIDTH'(item_value);
  assign full  = (cnt == CNT_W'(DEPTH));

  always_comb begin
    cnt_next  = cnt;
    ok_next   = 1'b0;
    read_next = '0;
    for (int i = 0; i < DEPTH; i++) entries_next[i] = entries[i];
    unique case (command)
      CMD_APPEND: begin
        if (!full) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CMP_W'(i) == cnt_c) entries_next[i] = val;
          end
          cnt_next = cnt + 1'b1;
          ok_next  = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (!full && pos_c <= cnt_c) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CMP_W'(i) == pos_c) begin
              entries_next[i] = val;
            end else if (i > 0 && CMP_W'(i) > pos_c && CMP_W'(i) <= cnt_c) begin
              entries_next[i] = entries[(i > 0) ? i - 1 : 0];
            end
          end
          cnt_next = cnt + 1'b1;
          ok_next  = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_c < cnt_c) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (CMP_W'(i) >= pos_c && CMP_W'(i + 1) < cnt_c)
              entries_next[i] = entries[i + 1];
          end
          cnt_next = cnt - 1'b1;
          ok_next  = 1'b1;
        end
      end
      CMD_GET: begin
        if (pos_c < cnt_c) begin
          read_next = VALUE_W'(entries[position[IDX_W-1:0]]);
          ok_next   = 1'b1;
        end
      end
      default: ok_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= cnt_next;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < DEPTH; i++) entries[i] <= entries_next[i];
      ok         <= ok_next;
      read_value <= read_next;
    end
  end

  assign count        = COUNT_W'(cnt);
  assign empty_res    = (cnt == '0);
  assign status.full  = full;
  assign status.empty = (cnt == '0);

endmodule

`default_nettype wire

>>> hw/rtl/indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// indexed_list_store_top
// latency: a result is valid the cycle after its command transaction
// throughput: one command per cycle unless a result waits unclaimed; the
//   register array shifts in parallel, and the result register lets the next
//   command enter while a result is being taken
// reset: synchronous rst empties the list (count 0); entries stay undefined
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_list_store_top_assert.svh"

module indexed_list_store_top (
  input  wire    clk,
  input  wire    rst,
  ils_cmd_if.sink   cmd,
  ils_res_if.source res
);
  import ils_pkg::*;

  // load command from the controller, full and empty status from the datapath
  ctl_cmd_t   ctl;
  dp_status_t status;

  // controller owns the handshake: one load per accepted transaction,
  // result valid held until the sink takes it
  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (ctl)
  );

  // datapath: the list itself, fill count and registered result fields
  ils_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ctl),
    .command    (cmd.command),
    .position   (cmd.position),
    .item_value (cmd.item_value),
    .status     (status),
    .ok         (res.ok),
    .read_value (res.read_value),
    .count      (res.count),
    .empty_res  (res.empty_res)
  );

  // every accepted transaction produces a result in the next cycle
  `ILS_ASSERT_NEXT(a_result_follows, clk, rst, cmd.valid && cmd.ready, res.valid)
  // input stalls only while a result waits unclaimed
  `ILS_ASSERT_SAME(a_stall_reason, clk, rst, !cmd.ready, res.valid && !res.ready)
  // the count moves only with an accepted transaction
  `ILS_ASSERT_NEXT(a_count_hold, clk, rst, !(cmd.valid && cmd.ready), $stable(res.count))
  // the count never exceeds the list depth
  `ILS_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, res.count <= COUNT_W'(DEPTH))
  // a full list is never reported empty
  `ILS_ASSERT_SAME(a_full_not_empty, clk, rst, status.full, !status.empty)

endmodule

`default_nettype wire
